/* src/cpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

	localparam int SLOTS_DEFAULT     = 256;
	localparam int COMP_BITS_DEFAULT = 16;
	localparam int IN_BITS           = 16;
	localparam int TOL_BITS          = 16;
	localparam int SLOT_OUT_BITS     = 8;
	localparam int STATUS_BITS       = 2;

	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd655;

	localparam logic [STATUS_BITS-1:0] STATUS_FOUND    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} cpf_state_t;

endpackage

`default_nettype wire

/* src/cpf_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpf_in_if
	import cpf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [IN_BITS-1:0] red;
	logic [IN_BITS-1:0] green;
	logic [IN_BITS-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* src/cpf_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpf_out_if
	import cpf_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [SLOT_OUT_BITS-1:0] slot_index;
	logic [STATUS_BITS-1:0]   status;

	modport source (output valid, output slot_index, output status, input ready);
	modport sink   (input valid, input slot_index, input status, output ready);
endinterface

`default_nettype wire

/* src/colour_palette_find_or_insert_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel     | dir | handshake       | payload
// colour_in   | in  | valid / ready   | red, green, blue (16 bits each)
// result_out  | out | valid / ready   | slot_index (8), status (2)
// cfg         | in  | cfg_we          | cfg_wdata = tolerance (16)
//
// the scan reads one palette slot per cycle through the single memory read port and one
// shared comparator.
// colour_in is ready only while idle; the result register lets the next colour be taken
// while a result still waits on result_out.
// reset clears control state only; slots are read only below next_free, so no clearing pass.

module colour_palette_find_or_insert_core
	import cpf_pkg::*;
#(
	parameter int SLOTS          = SLOTS_DEFAULT,
	parameter int COMPONENT_BITS = COMP_BITS_DEFAULT
) (
	input  wire                clk,
	input  wire                arst_n,
	cpf_in_if.sink             colour_in,
	cpf_out_if.source          result_out,
	input  wire                cfg_we,
	input  wire [TOL_BITS-1:0] cfg_wdata
);

	localparam int AW   = $clog2(SLOTS);
	localparam int NF_W = $clog2(SLOTS + 1);
	localparam int CB   = COMPONENT_BITS;
	localparam int EW   = 3 * CB;
	localparam int CW   = (CB > TOL_BITS) ? CB : TOL_BITS;

	cpf_state_t state_q, state_d;

	logic [TOL_BITS-1:0] tol_q;
	logic [NF_W-1:0]     next_free_q;
	logic [NF_W-1:0]     rd_idx_q;
	logic [EW-1:0]       col_q;
	logic                found_q;
	logic [AW-1:0]       found_idx_q;

	logic [EW-1:0]       palette [SLOTS];
	logic [EW-1:0]       rd_data_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic                cmp_vld_s1;

	logic                out_vld_q;
	logic [SLOT_OUT_BITS-1:0] out_slot_q;
	logic [STATUS_BITS-1:0]   out_status_q;

	logic                in_ready;
	logic                rd_en;
	logic                load_out;
	logic                ins_en;
	logic                match;
	logic                scan_end;
	logic                has_space;
	logic [EW-1:0]       col_d;
	logic [AW-1:0]       slot_sel;
	logic [31:0]         slot_ext;
	logic [STATUS_BITS-1:0] status_d;
	logic [2:0]          comp_ok;

	// input masked or widened to the stored component width
	always_comb begin
		logic [31:0] r_ext, g_ext, b_ext;
		r_ext = 32'(colour_in.red);
		g_ext = 32'(colour_in.green);
		b_ext = 32'(colour_in.blue);
		col_d = {b_ext[CB-1:0], g_ext[CB-1:0], r_ext[CB-1:0]};
	end

	// shared comparator on the slot read last cycle
	always_comb begin
		logic [CB-1:0] a, b, d;
		for (int k = 0; k < 3; k++) begin
			a = rd_data_s1[k*CB +: CB];
			b = col_q[k*CB +: CB];
			d = (a >= b) ? (a - b) : (b - a);
			comp_ok[k] = CW'(d) < CW'(tol_q);
		end
	end

	assign match     = cmp_vld_s1 && (&comp_ok);
	assign scan_end  = !cmp_vld_s1 && (rd_idx_q >= next_free_q);
	assign has_space = next_free_q < NF_W'(SLOTS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (colour_in.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match || scan_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_vld_q || result_out.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		load_out = 1'b0;
		ins_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_SCAN: begin
				rd_en = !match && (rd_idx_q < next_free_q);
			end
			ST_FINISH: begin
				load_out = !out_vld_q || result_out.ready;
				ins_en   = load_out && !found_q && has_space;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (found_q) begin
			slot_sel = found_idx_q;
			status_d = STATUS_FOUND;
		end else if (has_space) begin
			slot_sel = next_free_q[AW-1:0];
			status_d = STATUS_INSERTED;
		end else begin
			slot_sel = '0;
			status_d = STATUS_FULL;
		end
		slot_ext = 32'(slot_sel);
	end

	assign colour_in.ready       = in_ready;
	assign result_out.valid      = out_vld_q;
	assign result_out.slot_index = out_slot_q;
	assign result_out.status     = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tol_q       <= TOL_RESET;
			next_free_q <= NF_W'(1);
			cmp_vld_s1  <= 1'b0;
			found_q     <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= rd_en;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (colour_in.valid && in_ready) begin
				found_q <= 1'b0;
			end else if (match) begin
				found_q <= 1'b1;
			end
			if (ins_en) begin
				next_free_q <= NF_W'(next_free_q + 1'b1);
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (colour_in.valid && in_ready) begin
			col_q    <= col_d;
			rd_idx_q <= NF_W'(1);
		end else if (rd_en) begin
			rd_idx_q <= NF_W'(rd_idx_q + 1'b1);
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (match) begin
			found_idx_q <= cmp_idx_s1;
		end
		if (load_out) begin
			out_slot_q   <= slot_ext[SLOT_OUT_BITS-1:0];
			out_status_q <= status_d;
		end
	end

	// palette storage, one read and one write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= palette[rd_idx_q[AW-1:0]];
		end
		if (ins_en) begin
			palette[next_free_q[AW-1:0]] <= col_q;
		end
	end

	a_next_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q >= NF_W'(1)) && (next_free_q <= NF_W'(SLOTS)))
		else $error("next_free out of range");

	a_insert_bumps: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status_d == STATUS_INSERTED) |=>
		(next_free_q == NF_W'($past(next_free_q) + 1'b1)))
		else $error("insert did not advance next_free");

	a_found_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && found_q) |->
		((found_idx_q != '0) && (NF_W'(found_idx_q) < next_free_q)))
		else $error("match reported on an unused slot");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(colour_in.valid && colour_in.ready) |=> (state_q == ST_SCAN && !cmp_vld_s1))
		else $error("transfer did not start a scan");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && status_d == STATUS_FULL) |-> (!ins_en && !has_space))
		else $error("write while palette full");

endmodule

`default_nettype wire
